@@ src/deq_pkg.sv @@
// deq_pkg: shared constants, codes and types of the double-ended queue
`timescale 1ns / 1ps
package deq_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;
  localparam int OUT_RAW_W   = VALUE_W + STATUS_W + FILL_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]             count_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic push_back;
    logic pop_back;
  } cell_ctrl_t;

endpackage

@@ src/deq_cell.sv @@
// deq_cell: one slot of the shift chain with its data word and occupancy flag
`timescale 1ns / 1ps
module deq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deq_pkg::cell_ctrl_t ctrl_i,
  input  deq_pkg::word_t    push_i,
  input  deq_pkg::word_t    left_data_i,
  input  logic              left_valid_i,
  input  deq_pkg::word_t    right_data_i,
  input  logic              right_valid_i,
  output deq_pkg::word_t    data_o,
  output logic              valid_o,
  output logic              tail_o,
  output deq_pkg::word_t    tail_data_o
);
  import deq_pkg::*;

  word_t data_q, data_d;
  logic  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.shift_right) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.shift_left) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.push_back) begin
      // first empty slot behind the last word takes the value
      if (!valid_q && left_valid_i) begin
        data_d  = push_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_back) begin
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign tail_o      = valid_q && !right_valid_i;
  assign tail_data_o = tail_o ? data_q : '0;

endmodule

@@ src/double_ended_queue_unit.sv @@
// double_ended_queue_unit: bounded deque of signed words built as a chain of shift cells
`timescale 1ns / 1ps
// Takes one item per clock cycle while the result register is empty or being
// read, and returns one result item per item through that register in the cycle
// after acceptance; on acceptance every cell loads from its neighbor, the push
// value or itself. Item: tuser = operation (push front, push back, pop front,
// pop back), tdata = push value. Result: popped word, status (done, pop on empty,
// push on full) and fill level after the operation. Refused operations leave the
// queue unchanged. No clearing pass after reset; the queue is empty at once.
module double_ended_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [deq_pkg::VALUE_W-1:0]       s_axis_tdata,  // push_value
  input  logic [deq_pkg::OP_W-1:0]          s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // pop_value, status, fill_level
);
  import deq_pkg::*;

  op_e        op;
  logic       in_fire;
  logic       is_full, is_empty;
  word_t      push_word;
  cell_ctrl_t ctrl;

  word_t             cell_data [DEPTH];
  word_t             cell_tail_data [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_tail;
  word_t             back_word;

  count_t  count_q, count_d;
  logic    out_valid_q;
  logic    [VALUE_W-1:0] pop_q, pop_d;
  status_e status_q, status_d;
  logic    [FILL_W-1:0] fill_q;

  assign op        = op_e'(s_axis_tuser);
  assign push_word = DATA_WIDTH'(signed'(s_axis_tdata));
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_data, right_data;
    logic  left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_data  = push_word;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .push_i        (push_word),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .tail_o        (cell_tail[i]),
      .tail_data_o   (cell_tail_data[i])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail_data[i];
    end
  end

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    pop_d    = '0;
    status_d = STAT_DONE;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          ctrl.shift_right = in_fire;
          count_d          = count_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          ctrl.push_back = in_fire;
          count_d        = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          ctrl.shift_left = in_fire;
          count_d         = count_q - 1'b1;
          pop_d           = VALUE_W'(cell_data[0]);
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          ctrl.pop_back = in_fire;
          count_d       = count_q - 1'b1;
          pop_d         = VALUE_W'(back_word);
        end
      end
      default: begin
        status_d = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      fill_q   <= FILL_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, fill_q, status_q, pop_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(cell_valid)) == count_q)
    else $error("occupied cells disagree with fill count");

  a_head_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == !is_empty)
    else $error("words not packed at the front of the chain");

  a_single_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_tail))
    else $error("more than one tail cell");

  a_full_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
    |=> status_q == STAT_FULL && fill_q == FILL_W'(DEPTH))
    else $error("push on full queue not refused");

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking testbench of the double-ended queue unit with a result scoreboard
`timescale 1ns / 1ps
module tb_top;
  import deq_pkg::*;

  localparam int ITEMS_PER_PHASE = 310;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct {
    logic [VALUE_W-1:0] pop_value;
    status_e            status;
    logic [FILL_W-1:0]  fill_level;
  } deq_result_t;

  class deque_scoreboard;
    word_t       ring[DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned level;
    deq_result_t expected_q[$];
    int          errors;

    function new();
      head   = 0;
      tail   = 0;
      level  = 0;
      errors = 0;
    endfunction

    function void note_item(op_e op, logic [VALUE_W-1:0] value);
      deq_result_t r;
      r.pop_value = '0;
      r.status    = STAT_DONE;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (level >= DEPTH) begin
            r.status = STAT_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            head       = (head == 0) ? DEPTH - 1 : head - 1;
            ring[head] = word_t'(value);
            level++;
          end else begin
            ring[tail] = word_t'(value);
            tail       = (tail + 1 >= DEPTH) ? 0 : tail + 1;
            level++;
          end
        end
        default: begin
          if (level == 0) begin
            r.status = STAT_EMPTY;
          end else if (op == OP_POP_FRONT) begin
            r.pop_value = VALUE_W'(ring[head]);
            head        = (head + 1 >= DEPTH) ? 0 : head + 1;
            level--;
          end else begin
            tail        = (tail == 0) ? DEPTH - 1 : tail - 1;
            r.pop_value = VALUE_W'(ring[tail]);
            level--;
          end
        end
      endcase
      r.fill_level = FILL_W'(level);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      deq_result_t r;
      logic [VALUE_W-1:0]  got_value;
      logic [STATUS_W-1:0] got_status;
      logic [FILL_W-1:0]   got_fill;
      got_value  = data[VALUE_W-1:0];
      got_status = data[VALUE_W +: STATUS_W];
      got_fill   = data[VALUE_W+STATUS_W +: FILL_W];
      if (expected_q.size() == 0) begin
        $error("result item with none expected: tdata %h", data);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (got_value !== r.pop_value) begin
        $error("pop_value: expected %h, actual %h", r.pop_value, got_value);
        errors++;
      end
      if (got_status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, got_status);
        errors++;
      end
      if (got_fill !== r.fill_level) begin
        $error("fill_level: expected %0d, actual %0d", r.fill_level, got_fill);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [VALUE_W-1:0]     s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_req = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     quiet_cycles = 0;
  deque_scoreboard sb;

  double_ended_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(op_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_top failed");
          $finish;
        end
      end
    end
  end

  task automatic send_item(op_e op, logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned push_pct;
    op_e         op;
    push_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      // swing between filling and draining so full and empty both come up
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      send_item(op, $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue, extreme words, ring wrap at both ends, full queue
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_PUSH_BACK, 32'h7fff_ffff);
    send_item(OP_POP_BACK, 32'h0000_0000);
    send_item(OP_POP_FRONT, 32'hffff_ffff);
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
    end
    send_item(OP_PUSH_FRONT, 32'hffff_ffff);
    send_item(OP_PUSH_BACK, 32'h0000_0000);
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_BACK, $urandom);

    hold_req = 1'b1;
    send_random(ITEMS_PER_PHASE);

    send_idle_pct  = 81;
    recv_stall_pct = 0;
    send_random(ITEMS_PER_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_random(ITEMS_PER_PHASE);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    send_random(ITEMS_PER_PHASE);

    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
